/* hw/rtl/qr_pkg.sv */
// Shared constants and helpers for the quadratic root reflection block.
// No dependencies; imported by qr_sqrt and the top level, and used by the testbench.
`default_nettype none

package qr_pkg;

	localparam int QR_DATA_WIDTH = 32;
	localparam int QR_FRAC_BITS  = 16;

	function automatic int qr_max(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// pipelined square root width: even count of radicand bits
	function automatic int qr_sq_width(input int w, input int f);
		int dlen;
		dlen = qr_max(2 * w, w + f + 2) + 1;
		return dlen + (dlen % 2);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/qr_sqrt.sv */
// Pipelined integer square root (floor), one result bit per register stage.
// Depends on qr_pkg for width helpers; sideband data travels with each item.
`default_nettype none

module qr_sqrt #(
	parameter int SQW = 66,
	parameter int SBW = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [SQW-1:0]       radicand,
	input  wire logic [SBW-1:0]       sb_in,
	output logic                      out_valid,
	output logic [qr_pkg::qr_max(SQW/2, 2)-1:0] root,
	output logic [SBW-1:0]            sb_out
);
	import qr_pkg::*;

	localparam int RTW = qr_max(SQW / 2, 2);
	localparam int NST = SQW / 2;
	localparam int RW  = RTW + 2;

	logic [SQW-1:0] dat_s  [1:NST];
	logic [RW-1:0]  rem_s  [1:NST];
	logic [RTW-1:0] root_s [1:NST];
	logic [SBW-1:0] sb_s   [1:NST];
	logic           vld_s  [1:NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic [SQW-1:0] d_prev;
		logic [RW-1:0]  r_prev;
		logic [RTW-1:0] q_prev;
		logic [SBW-1:0] b_prev;
		logic           v_prev;
		logic [RW+1:0]  cat;
		logic [RW+2:0]  diff;

		if (k == 0) begin : g_in
			assign d_prev = radicand;
			assign r_prev = '0;
			assign q_prev = '0;
			assign b_prev = sb_in;
			assign v_prev = in_valid;
		end else begin : g_mid
			assign d_prev = dat_s[k];
			assign r_prev = rem_s[k];
			assign q_prev = root_s[k];
			assign b_prev = sb_s[k];
			assign v_prev = vld_s[k];
		end

		// trial subtract of 4*root+1 against the remainder with two new bits
		always_comb begin
			cat  = {r_prev, d_prev[SQW-1:SQW-2]};
			diff = {1'b0, cat} - {1'b0, {(RW - RTW){1'b0}}, q_prev, 2'b01};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dat_s[k+1] <= d_prev << 2;
				sb_s[k+1]  <= b_prev;
				if (!diff[RW+2]) begin
					rem_s[k+1]  <= diff[RW-1:0];
					root_s[k+1] <= {q_prev[RTW-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= cat[RW-1:0];
					root_s[k+1] <= {q_prev[RTW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[NST];
	assign root      = root_s[NST];
	assign sb_out    = sb_s[NST];

endmodule

`default_nettype wire

/* hw/rtl/qr_div.sv */
// Two-lane pipelined restoring divider, one quotient bit per register stage.
// Unsigned, truncating; a zero divisor gives all ones. No package needs.
`default_nettype none

module qr_div #(
	parameter int NW   = 51,
	parameter int DENW = 35,
	parameter int SBW  = 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic [NW-1:0]   num_x,
	input  wire logic [DENW-1:0] den_x,
	input  wire logic [NW-1:0]   num_y,
	input  wire logic [DENW-1:0] den_y,
	input  wire logic [SBW-1:0]  sb_in,
	output logic                 out_valid,
	output logic [NW-1:0]        quo_x,
	output logic [NW-1:0]        quo_y,
	output logic [SBW-1:0]       sb_out
);

	logic [NW-1:0]   num_s [1:NW][2];
	logic [DENW-1:0] den_s [1:NW][2];
	logic [DENW-1:0] rem_s [1:NW][2];
	logic [NW-1:0]   quo_s [1:NW][2];
	logic [SBW-1:0]  sb_s  [1:NW];
	logic            vld_s [1:NW];

	for (genvar k = 0; k < NW; k++) begin : g_st
		logic [NW-1:0]   n_prev [2];
		logic [DENW-1:0] d_prev [2];
		logic [DENW-1:0] r_prev [2];
		logic [NW-1:0]   q_prev [2];
		logic [SBW-1:0]  b_prev;
		logic            v_prev;
		logic [DENW:0]   cat    [2];
		logic [DENW+1:0] diff   [2];

		if (k == 0) begin : g_in
			assign n_prev[0] = num_x;
			assign n_prev[1] = num_y;
			assign d_prev[0] = den_x;
			assign d_prev[1] = den_y;
			assign r_prev[0] = '0;
			assign r_prev[1] = '0;
			assign q_prev[0] = '0;
			assign q_prev[1] = '0;
			assign b_prev    = sb_in;
			assign v_prev    = in_valid;
		end else begin : g_mid
			assign n_prev = num_s[k];
			assign d_prev = den_s[k];
			assign r_prev = rem_s[k];
			assign q_prev = quo_s[k];
			assign b_prev = sb_s[k];
			assign v_prev = vld_s[k];
		end

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				cat[l]  = {r_prev[l], n_prev[l][NW-1]};
				diff[l] = {1'b0, cat[l]} - {2'b00, d_prev[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k+1] <= b_prev;
				for (int l = 0; l < 2; l++) begin
					num_s[k+1][l] <= n_prev[l] << 1;
					den_s[k+1][l] <= d_prev[l];
					if (!diff[l][DENW+1]) begin
						rem_s[k+1][l] <= diff[l][DENW-1:0];
						quo_s[k+1][l] <= {q_prev[l][NW-2:0], 1'b1};
					end else begin
						rem_s[k+1][l] <= cat[l][DENW-1:0];
						quo_s[k+1][l] <= {q_prev[l][NW-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign quo_x     = quo_s[NW][0];
	assign quo_y     = quo_s[NW][1];
	assign sb_out    = sb_s[NW];

endmodule

`default_nettype wire

/* hw/rtl/quadratic_root_unit_circle_reflect.sv */
// Quadratic factor x^2 + r*x + t (signed fixed point) in, factor with all
// roots reflected into the unit circle out. Uses qr_pkg, qr_sqrt, qr_div.
//
// Input stream s_*: tdata = {t, r}, r in the low DATA_WIDTH bits.
// Output stream m_*: tdata = {new_const, new_linear}, tuser flags.
// One item may enter every cycle while s_tready is high; each item yields exactly one result.
// Default format is 32-bit Q16.16. The pipeline runs through
// three front stages (capture, magnitudes and r^2, discriminant), one
// stage per root bit of the square root, one stage to form the divider
// operands, one stage per quotient bit of the two-lane divider, then root
// selection, the product/sum stage and the output register.
// Reset clears every valid bit; the block is empty afterward and no
// clearing pass is needed. When the receiver stalls with a result held,
// the pipeline keeps moving as long as its last stage is empty; it stops
// as a whole, and s_tready drops, only when a finished item would have
// to enter the held output register.
`default_nettype none

module quadratic_root_unit_circle_reflect #(
	parameter int DATA_WIDTH = qr_pkg::QR_DATA_WIDTH,
	parameter int FRAC_BITS  = qr_pkg::QR_FRAC_BITS
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     s_tvalid,
	output logic                                          s_tready,
	// coef_linear, coef_const, zero pad
	input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]        s_tdata,
	output logic                                          m_tvalid,
	input  wire logic                                     m_tready,
	// new_linear, new_const, zero pad
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]             m_tdata,
	// was_changed, root_kind, div_fault, saturated
	output logic [3:0]                                    m_tuser
);
	import qr_pkg::*;

	localparam int W    = DATA_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int TDW  = ((2 * W + 7) / 8) * 8;
	localparam int SQW  = qr_sq_width(W, F);
	localparam int RTW  = qr_max(SQW / 2, 2);
	localparam int AW   = qr_max(W, RTW) + 1;
	localparam int DENW = AW + 1;
	localparam int NW   = qr_max(AW + F, 2 * F + 2) + 1;
	localparam int M1W  = F + 2;
	localparam int PW   = M1W + NW;
	localparam int SUMW = NW + 2;

	typedef struct packed {
		logic [W-1:0] r;
		logic [W-1:0] t;
		logic [W-1:0] rmag;
		logic [W-1:0] tmag;
		logic         rneg;
		logic         tneg;
		logic         zero;
		logic         cplx;
	} sb1_t;

	typedef struct packed {
		logic [W-1:0]  r;
		logic [W-1:0]  t;
		logic          rneg;
		logic          tneg;
		logic          zero;
		logic          cplx;
		logic          cbig;
		logic          big1;
		logic          big2;
		logic [AW-2:0] ahalf;
	} sb2_t;

	logic en;
	logic out_en;

	// front stages
	logic [W-1:0]   r_s1, t_s1;
	logic           v_s1;
	sb1_t           sb_s2;
	logic [2*W-1:0] rsq_s2;
	logic           v_s2;
	sb1_t           sb_s3;
	logic [SQW-1:0] d_s3;
	logic           v_s3;

	// square root
	logic           sq_valid;
	logic [RTW-1:0] sq_root;
	logic [$bits(sb1_t)-1:0] sq_sb;
	sb1_t           sq_sbs;

	// divider
	logic [NW-1:0]   nx_s4, ny_s4;
	logic [DENW-1:0] dx_s4, dy_s4;
	sb2_t            sb_s4;
	logic            v_s4;
	logic            dv_valid;
	logic [NW-1:0]   qx, qy;
	logic [$bits(sb2_t)-1:0] dv_sb;
	sb2_t            dv_sbs;

	// back end
	logic [M1W-1:0]  m1_s5;
	logic [NW-1:0]   m2_s5, qx_s5;
	sb2_t            sb_s5;
	logic            v_s5;
	logic [PW-1:0]   prod_s6;
	logic [SUMW-1:0] sum_s6;
	logic [NW-1:0]   qx_s6, qy_s6;
	sb2_t            sb_s6;
	logic            v_s6;

	logic            out_valid_q;
	logic [W-1:0]    lin_q, cst_q;
	logic            chg_q, kind_q, fault_q, sat_q;

	// output register loads only when free or being drained; the rest of the
	// pipeline may also advance while its last stage holds a bubble
	assign out_en   = !out_valid_q || m_tready;
	assign en       = out_en || !v_s6;
	assign s_tready = en;

	// ---- stage 1: capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_valid;
			v_s5 <= dv_valid;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= s_tdata[W-1:0];
			t_s1 <= s_tdata[2*W-1:W];
		end
	end

	// ---- stage 2: magnitudes and r^2
	logic [W-1:0] rmag_c, tmag_c;
	always_comb begin
		rmag_c = r_s1[W-1] ? (~r_s1 + 1'b1) : r_s1;
		tmag_c = t_s1[W-1] ? (~t_s1 + 1'b1) : t_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s2.r    <= r_s1;
			sb_s2.t    <= t_s1;
			sb_s2.rmag <= rmag_c;
			sb_s2.tmag <= tmag_c;
			sb_s2.rneg <= r_s1[W-1];
			sb_s2.tneg <= t_s1[W-1];
			sb_s2.zero <= (rmag_c == '0) && (tmag_c == '0);
			sb_s2.cplx <= 1'b0;
			rsq_s2     <= rmag_c * rmag_c;
		end
	end

	// ---- stage 3: discriminant D = r^2 - 4t*2^F
	logic [SQW-1:0] rsq_w, tq_w;
	logic           cplx_c;
	sb1_t           sb3_c;
	always_comb begin
		rsq_w  = SQW'(rsq_s2);
		tq_w   = SQW'(sb_s2.tmag) << (F + 2);
		cplx_c = !sb_s2.tneg && (rsq_w < tq_w);
		sb3_c      = sb_s2;
		sb3_c.cplx = cplx_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s3 <= sb3_c;
			if (cplx_c) begin
				d_s3 <= '0;
			end else if (sb_s2.tneg) begin
				d_s3 <= rsq_w + tq_w;
			end else begin
				d_s3 <= rsq_w - tq_w;
			end
		end
	end

	qr_sqrt #(
		.SQW (SQW),
		.SBW ($bits(sb1_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.radicand  (d_s3),
		.sb_in     (sb_s3),
		.out_valid (sq_valid),
		.root      (sq_root),
		.sb_out    (sq_sb)
	);

	assign sq_sbs = sq_sb;

	// ---- stage 4: root magnitude A = |r| + q, reflection tests, divider operands
	logic [AW-1:0] a_c;
	logic [NW-1:0] a_w, tm_w;
	logic          big1_c, big2_c, cbig_c;
	always_comb begin
		a_c    = AW'(sq_sbs.rmag) + AW'(sq_root);
		a_w    = NW'(a_c);
		tm_w   = NW'(sq_sbs.tmag);
		big1_c = a_w > (NW'(1) << (F + 1));
		big2_c = (tm_w << 1) > a_w;
		cbig_c = tm_w > (NW'(1) << F);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s4.r     <= sq_sbs.r;
			sb_s4.t     <= sq_sbs.t;
			sb_s4.rneg  <= sq_sbs.rneg;
			sb_s4.tneg  <= sq_sbs.tneg;
			sb_s4.zero  <= sq_sbs.zero;
			sb_s4.cplx  <= sq_sbs.cplx;
			sb_s4.cbig  <= cbig_c;
			sb_s4.big1  <= big1_c;
			sb_s4.big2  <= big2_c;
			sb_s4.ahalf <= a_c[AW-1:1];
			if (sq_sbs.cplx) begin
				nx_s4 <= NW'(sq_sbs.rmag) << F;
				dx_s4 <= DENW'(sq_sbs.tmag);
				ny_s4 <= NW'(1) << (2 * F);
				dy_s4 <= DENW'(sq_sbs.tmag);
			end else begin
				nx_s4 <= big1_c ? (NW'(1) << (2 * F + 1)) : (NW'(sq_sbs.rmag) << F);
				dx_s4 <= DENW'(a_c);
				ny_s4 <= big2_c ? (a_w << F) : (tm_w << (F + 1));
				dy_s4 <= big2_c ? (DENW'(sq_sbs.tmag) << 1) : DENW'(a_c);
			end
		end
	end

	qr_div #(
		.NW   (NW),
		.DENW (DENW),
		.SBW  ($bits(sb2_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num_x     (nx_s4),
		.den_x     (dx_s4),
		.num_y     (ny_s4),
		.den_y     (dy_s4),
		.sb_in     (sb_s4),
		.out_valid (dv_valid),
		.quo_x     (qx),
		.quo_y     (qy),
		.sb_out    (dv_sb)
	);

	assign dv_sbs = dv_sb;

	// ---- stage 5: pick root magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s5 <= dv_sbs;
			qx_s5 <= qx;
			m2_s5 <= qy;
			m1_s5 <= dv_sbs.big1 ? qx[M1W-1:0] : M1W'(dv_sbs.ahalf);
		end
	end

	// ---- stage 6: product and signed sum of the roots
	logic [SUMW-1:0] s1_c, s2_c;
	always_comb begin
		s1_c = sb_s5.rneg ? -SUMW'(m1_s5) : SUMW'(m1_s5);
		s2_c = (sb_s5.rneg != sb_s5.tneg) ? -SUMW'(m2_s5) : SUMW'(m2_s5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s6   <= sb_s5;
			qx_s6   <= qx_s5;
			qy_s6   <= m2_s5;
			// both real root magnitudes are at most one after reflection
			prod_s6 <= PW'(m1_s5) * PW'(m2_s5[M1W-1:0]);
			sum_s6  <= s1_c + s2_c;
		end
	end

	// ---- output register: saturation and case selection
	function automatic logic [W:0] sat_fn(input logic neg, input logic [PW-1:0] mag);
		logic [PW-1:0] lim;
		logic [PW-1:0] m;
		logic          s;
		lim = neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
		s   = mag > lim;
		m   = s ? lim : mag;
		return {s, neg ? -m[W-1:0] : m[W-1:0]};
	endfunction

	logic            sum_neg;
	logic [SUMW-1:0] sum_mag;
	logic [W:0]      lin_c, cst_c;
	logic            chg_c;
	always_comb begin
		sum_neg = sum_s6[SUMW-1];
		sum_mag = sum_neg ? -sum_s6 : sum_s6;
		if (sb_s6.cplx) begin
			lin_c = sat_fn(sb_s6.rneg, PW'(qx_s6));
			cst_c = sat_fn(1'b0, PW'(qy_s6));
			chg_c = sb_s6.cbig;
		end else begin
			lin_c = sat_fn(sum_neg, PW'(sum_mag));
			cst_c = sat_fn(sb_s6.tneg, prod_s6 >> F);
			chg_c = sb_s6.big1 || sb_s6.big2;
		end
		if (sb_s6.zero) begin
			chg_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			fault_q <= sb_s6.zero;
			kind_q  <= !sb_s6.cplx || sb_s6.zero;
			chg_q   <= chg_c;
			if (chg_c) begin
				lin_q <= lin_c[W-1:0];
				cst_q <= cst_c[W-1:0];
				sat_q <= lin_c[W] || cst_c[W];
			end else begin
				lin_q <= sb_s6.r;
				cst_q <= sb_s6.t;
				sat_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDW'({cst_q, lin_q});
	assign m_tuser  = {sat_q, fault_q, kind_q, chg_q};

	// ---- checks
	a_stall_only_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a held result");

	a_fault_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (!m_tuser[0] && !m_tuser[3] && m_tuser[1]))
		else $error("zero factor item reports a change");

	a_sat_needs_change: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[3]) |-> m_tuser[0])
		else $error("saturation flagged on an unchanged item");

	a_cplx_const_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1] && m_tuser[0]) |-> !m_tdata[2*W-1])
		else $error("reflected complex pair has negative constant");

endmodule

`default_nettype wire

/* test/quadratic_root_unit_circle_reflect_test.sv */
// Testbench for quadratic_root_unit_circle_reflect: streams coefficient pairs,
// predicts each reflected factor with an exact integer model and checks results.
// Depends on qr_pkg and the top-level RTL.
`default_nettype none

module quadratic_root_unit_circle_reflect_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = qr_pkg::QR_DATA_WIDTH;
	localparam int FB = qr_pkg::QR_FRAC_BITS;
	localparam int LATENCY = 91;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [DW-1:0] lin;
		logic [DW-1:0] cst;
		logic          changed;
		logic          kind;
		logic          fault;
		logic          sat;
	} factor_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [2*DW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [2*DW-1:0] m_tdata;
	logic [3:0] m_tuser;

	factor_t reflected_q[$];
	int errors = 0;
	int idle_pct = 15;
	bit rx_hold = 1'b0;
	int quiet_cycles = 0;

	quadratic_root_unit_circle_reflect u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	// saturate a signed magnitude to DW bits
	function automatic logic [DW-1:0] clip(input bit neg, input logic [255:0] mag,
			inout bit sat);
		logic [255:0] lim;
		lim = neg ? (256'd1 << (DW-1)) : ((256'd1 << (DW-1)) - 1);
		if (mag > lim) begin
			mag = lim;
			sat = 1'b1;
		end
		return neg ? DW'(-mag) : DW'(mag);
	endfunction

	function automatic logic [255:0] isqrt(input logic [255:0] x);
		logic [255:0] res, c;
		res = 0;
		for (int b = 127; b >= 0; b--) begin
			c = res | (256'd1 << b);
			if (c * c <= x) res = c;
		end
		return res;
	endfunction

	function automatic factor_t reflect_factor(input logic [DW-1:0] r, input logic [DW-1:0] t);
		factor_t o;
		bit rneg, tneg, sat, big1, big2, n1, n2;
		logic [255:0] rmag, tmag, rsq, tq, d, a, m1, m2, prod, t2;
		logic signed [255:0] s1, s2, sum;
		rneg = r[DW-1];
		tneg = t[DW-1];
		rmag = rneg ? 256'(DW'(-r)) : 256'(r);
		tmag = tneg ? 256'(DW'(-t)) : 256'(t);
		sat = 0;
		o = '{lin: r, cst: t, changed: 0, kind: 1, fault: 0, sat: 0};
		if (rmag == 0 && tmag == 0) begin
			o.fault = 1;
			return o;
		end
		rsq = rmag * rmag;
		tq = tmag << (FB + 2);
		if (!tneg && rsq < tq) begin
			o.kind = 0;
			if (tmag > (256'd1 << FB)) begin
				o.lin = clip(rneg, (rmag << FB) / tmag, sat);
				o.cst = clip(0, (256'd1 << (2*FB)) / tmag, sat);
				o.changed = 1;
				o.sat = sat;
			end
			return o;
		end
		d = tneg ? rsq + tq : rsq - tq;
		a = rmag + isqrt(d);
		t2 = tmag << 1;
		big1 = a > (256'd1 << (FB + 1));
		big2 = t2 > a;
		if (!big1 && !big2) return o;
		n1 = rneg;
		n2 = rneg != tneg;
		m1 = big1 ? (256'd1 << (2*FB+1)) / a : a >> 1;
		m2 = big2 ? (a << FB) / t2 : (tmag << (FB+1)) / a;
		s1 = n1 ? -$signed(m1) : $signed(m1);
		s2 = n2 ? -$signed(m2) : $signed(m2);
		sum = s1 + s2;
		o.lin = clip(sum < 0, sum < 0 ? -sum : sum, sat);
		prod = (m1 * m2) >> FB;
		o.cst = clip(n1 != n2, prod, sat);
		o.changed = 1;
		o.sat = sat;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [DW-1:0] got,
			input logic [DW-1:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	// leaves tvalid high after the accepting edge and returns at the following
	// falling edge; the next call then drops it or presents new data
	task automatic send_factor(input logic [DW-1:0] r, input logic [DW-1:0] t);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {t, r};
		reflected_q.push_back(reflect_factor(r, t));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver ready pattern
	always @(negedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		factor_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{lin: m_tdata[DW-1:0], cst: m_tdata[2*DW-1:DW], changed: m_tuser[0],
				kind: m_tuser[1], fault: m_tuser[2], sat: m_tuser[3]};
			if (reflected_q.size() == 0) begin
				report_mismatch("unexpected item", got.lin, '0);
			end else begin
				want = reflected_q.pop_front();
				if (got.lin !== want.lin) report_mismatch("new_linear", got.lin, want.lin);
				if (got.cst !== want.cst) report_mismatch("new_const", got.cst, want.cst);
				if (got.changed !== want.changed)
					report_mismatch("was_changed", got.changed, want.changed);
				if (got.kind !== want.kind) report_mismatch("root_kind", got.kind, want.kind);
				if (got.fault !== want.fault) report_mismatch("div_fault", got.fault, want.fault);
				if (got.sat !== want.sat) report_mismatch("saturated", got.sat, want.sat);
			end
		end
	end

	// watchdog on accepted items
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	function automatic logic [DW-1:0] q16(input int whole);
		return DW'(whole <<< FB);
	endfunction

	task automatic test_directed();
		logic [DW-1:0] mx, mn;
		mx = {1'b0, {(DW-1){1'b1}}};
		mn = {1'b1, {(DW-1){1'b0}}};
		send_factor('0, '0);                       // zero factor
		send_factor(q16(1), q16(4));               // complex, t > 1
		send_factor(q16(1), q16(1) >> 1);          // complex, t <= 1
		send_factor('0, q16(1));                   // complex, t exactly one
		send_factor(q16(-3), q16(2));              // real, roots 1 and 2
		send_factor(q16(1) >> 2, -(q16(1) >> 4));  // real, both inside
		send_factor(q16(5), q16(1));               // one root outside
		send_factor(mx, mx);
		send_factor(mn, mn);
		send_factor(mx, mn);
		send_factor(mn, mx);
		send_factor('0, mn);
		send_factor(mx, '0);
		send_factor(mn, '0);
		send_factor('0, DW'(1));
		send_factor(DW'(1), '0);
		send_factor(DW'(-1), DW'(-1));
		send_factor('0, q16(2) + 1);
		send_factor(q16(2), q16(1));               // double root at -1
	endtask

	function automatic logic [DW-1:0] rand_coef();
		case ($urandom_range(3))
			0: return DW'($urandom());
			1: return DW'($signed($urandom_range(2 << FB)) - (1 << FB));
			2: return DW'($signed($urandom_range(16 << FB)) - (8 << FB));
			default: return DW'($signed($urandom_range(1 << 12)) - (1 << 11));
		endcase
	endfunction

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) send_factor(rand_coef(), rand_coef());
	endtask

	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1'b1;
				repeat (300) @(posedge clk);
				rx_hold = 1'b0;
			end
			test_random(150);
		join
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(250);
		idle_pct = 0;
		test_random(150);
		idle_pct = 15;
		test_backpressure();
		test_random(150);
		s_tvalid <= 1'b0;
		while (reflected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && reflected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/qr_pkg.sv
hw/rtl/qr_sqrt.sv
hw/rtl/qr_div.sv
hw/rtl/quadratic_root_unit_circle_reflect.sv
test/quadratic_root_unit_circle_reflect_test.sv
